// ===== src/running_mean_standard_error_top_defines.svh =====
// Assertion macros used by the checker file of the running mean block.
`ifndef RUNNING_MEAN_STANDARD_ERROR_TOP_DEFINES_SVH
`define RUNNING_MEAN_STANDARD_ERROR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define RMSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define RMSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/rmse_pkg.sv =====
// Shared widths, constants and unit command types for the running mean block.
package rmse_pkg;

   localparam int AVG_W   = 32;
   localparam int SQ_W    = 48;
   localparam int VSUM_W  = 40;
   localparam int SSUM_W  = 56;
   localparam int IDX_W   = 7;
   localparam int CNT8_W  = 8;
   localparam int SE_W    = 32;

   localparam int OPND_W  = 64;
   localparam int QUO_W   = 56;
   localparam int DIVR_W  = 8;
   localparam int REM_W   = 35;
   localparam int STEP_W  = 6;

   localparam logic [CNT8_W-1:0] BLOCK_COUNT_RESET = 8'd100;
   localparam logic [CNT8_W-1:0] MIN_BLOCKS        = 8'd2;
   localparam logic [CNT8_W-1:0] MAX_BLOCKS        = 8'd128;

   localparam logic [STEP_W-1:0] DIV_STEPS  = 6'd56;
   localparam logic [STEP_W-1:0] ROOT_STEPS = 6'd32;

   localparam logic MODE_DIV  = 1'b0;
   localparam logic MODE_SQRT = 1'b1;

   typedef struct packed {
      logic              start;
      logic              mode;
      logic [OPND_W-1:0] operand;
      logic [DIVR_W-1:0] divisor;
   } rmse_cmd_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } rmse_res_type;

endpackage

// ===== src/running_mean_standard_error_top.sv =====
// Running mean and standard error of block averages: sequencer, sums and output register.
//
// Input channel req_: one block average (signed Q16.16) and its square
// (unsigned Q32.16) per transfer. Result channel rsp_: one result per input
// with the item index within the run, the running mean (signed Q16.16), the
// standard error of that mean (unsigned Q16.16, zero for the first item of a
// run) and a flag on the last item of the run. A transfer takes place when
// valid is high and stall is low.
// Configuration: csr_ carries the run length (8 bits, clamped to 2..128);
// write it while the block is idle. It applies from the next input item.
// The first item of a run needs only the mean division. Other items run three
// 56-step divisions and a 32-step square root on the one shared divide/root unit.
// A new item is taken only once the last result enters the output register,
// since req_stall drops as that result is registered.
// The output register holds a finished result while rsp_stall is high; the
// next item may be taken meanwhile and waits at its end until the register
// frees up. Reset empties the output, clears sums and count and sets the
// run length to 100.
module running_mean_standard_error_top import rmse_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [AVG_W-1:0]  req_block_average,
   input  logic        [SQ_W-1:0]   req_block_square,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic        [IDX_W-1:0]  rsp_item_index,
   output logic signed [AVG_W-1:0]  rsp_running_mean,
   output logic        [SE_W-1:0]   rsp_standard_error,
   output logic                     rsp_run_last,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic        [CNT8_W-1:0] csr_data
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_MEAN_GO  = 4'd1;
   localparam logic [3:0] S_MEAN_RUN = 4'd2;
   localparam logic [3:0] S_SQR      = 4'd3;
   localparam logic [3:0] S_MSQ_GO   = 4'd4;
   localparam logic [3:0] S_MSQ_RUN  = 4'd5;
   localparam logic [3:0] S_VAR_GO   = 4'd6;
   localparam logic [3:0] S_VAR_RUN  = 4'd7;
   localparam logic [3:0] S_ROOT_GO  = 4'd8;
   localparam logic [3:0] S_ROOT_RUN = 4'd9;
   localparam logic [3:0] S_DONE     = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [CNT8_W-1:0] block_count_ff, block_count_in;
   logic [VSUM_W-1:0] value_sum_ff, value_sum_in;
   logic [SSUM_W-1:0] square_sum_ff, square_sum_in;
   logic [IDX_W-1:0]  items_seen_ff, items_seen_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT8_W-1:0] n_ff, n_in;
   logic              last_ff, last_in;
   logic              mean_neg_ff, mean_neg_in;
   logic [SE_W-1:0]   mean_mag_ff, mean_mag_in;
   logic [SQ_W-1:0]   msq2_ff, msq2_in;
   logic [SSUM_W-1:0] var_ff, var_in;
   logic [SQ_W-1:0]   q_ff, q_in;
   logic [SE_W-1:0]   se_ff, se_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [AVG_W-1:0]  rsp_mean_ff, rsp_mean_in;
   logic [SE_W-1:0]   rsp_se_ff, rsp_se_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_take;
   logic [CNT8_W-1:0] eff_len;
   logic [CNT8_W-1:0] n_next;
   logic [VSUM_W-1:0] sum_mag;
   logic [2*SE_W-1:0] mean_sq;
   logic [SSUM_W:0]   var_diff;
   logic              out_free;

   rmse_cmd_type      cmd;
   rmse_res_type      res;

   rmse_unit u_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .res   (res)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (block_count_ff < MIN_BLOCKS) begin
         eff_len = MIN_BLOCKS;
      end else if (block_count_ff > MAX_BLOCKS) begin
         eff_len = MAX_BLOCKS;
      end else begin
         eff_len = block_count_ff;
      end
      n_next   = {1'b0, items_seen_ff} + 1'b1;
      sum_mag  = value_sum_ff[VSUM_W-1] ? (~value_sum_ff + 1'b1) : value_sum_ff;
      mean_sq  = mean_mag_ff * mean_mag_ff;
      var_diff = {1'b0, res.quotient} - {{(SSUM_W+1-SQ_W){1'b0}}, msq2_ff};
   end

   always_comb begin
      cmd.start   = 1'b0;
      cmd.mode    = MODE_DIV;
      cmd.operand = '0;
      cmd.divisor = n_ff;
      case (state_ff)
         S_MEAN_GO: begin
            cmd.start   = 1'b1;
            cmd.operand = OPND_W'(sum_mag);
         end
         S_MSQ_GO: begin
            cmd.start   = 1'b1;
            cmd.operand = OPND_W'(square_sum_ff);
         end
         S_VAR_GO: begin
            cmd.start   = 1'b1;
            cmd.operand = OPND_W'(var_ff);
            cmd.divisor = {1'b0, idx_ff};
         end
         S_ROOT_GO: begin
            cmd.start   = 1'b1;
            cmd.mode    = MODE_SQRT;
            cmd.operand = {q_ff, 16'b0};
         end
         default: begin
            cmd.start = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      block_count_in = block_count_ff;
      value_sum_in   = value_sum_ff;
      square_sum_in  = square_sum_ff;
      items_seen_in  = items_seen_ff;
      idx_in         = idx_ff;
      n_in           = n_ff;
      last_in        = last_ff;
      mean_neg_in    = mean_neg_ff;
      mean_mag_in    = mean_mag_ff;
      msq2_in        = msq2_ff;
      var_in         = var_ff;
      q_in           = q_ff;
      se_in          = se_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_index_in   = rsp_index_ff;
      rsp_mean_in    = rsp_mean_ff;
      rsp_se_in      = rsp_se_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         block_count_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               value_sum_in  = value_sum_ff
                             + {{(VSUM_W-AVG_W){req_block_average[AVG_W-1]}}, req_block_average};
               square_sum_in = square_sum_ff + {{(SSUM_W-SQ_W){1'b0}}, req_block_square};
               idx_in        = items_seen_ff;
               n_in          = n_next;
               last_in       = (n_next >= eff_len);
               state_in      = S_MEAN_GO;
            end
         end
         S_MEAN_GO: begin
            mean_neg_in = value_sum_ff[VSUM_W-1];
            state_in    = S_MEAN_RUN;
         end
         S_MEAN_RUN: begin
            if (res.done) begin
               mean_mag_in = res.quotient[SE_W-1:0];
               if (idx_ff == '0) begin
                  se_in    = '0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_SQR;
               end
            end
         end
         S_SQR: begin
            msq2_in  = mean_sq[2*SE_W-1:16];
            state_in = S_MSQ_GO;
         end
         S_MSQ_GO: begin
            state_in = S_MSQ_RUN;
         end
         S_MSQ_RUN: begin
            if (res.done) begin
               // clamp a negative variance to zero
               var_in   = var_diff[SSUM_W] ? '0 : var_diff[SSUM_W-1:0];
               state_in = S_VAR_GO;
            end
         end
         S_VAR_GO: begin
            state_in = S_VAR_RUN;
         end
         S_VAR_RUN: begin
            if (res.done) begin
               if (|res.quotient[QUO_W-1:SQ_W]) begin
                  q_in = '1;
               end else begin
                  q_in = res.quotient[SQ_W-1:0];
               end
               state_in = S_ROOT_GO;
            end
         end
         S_ROOT_GO: begin
            state_in = S_ROOT_RUN;
         end
         S_ROOT_RUN: begin
            if (res.done) begin
               se_in    = res.quotient[SE_W-1:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = idx_ff;
               rsp_mean_in  = mean_neg_ff ? (~mean_mag_ff + 1'b1) : mean_mag_ff;
               rsp_se_in    = se_ff;
               rsp_last_in  = last_ff;
               if (last_ff) begin
                  value_sum_in  = '0;
                  square_sum_in = '0;
                  items_seen_in = '0;
               end else begin
                  items_seen_in = n_ff[IDX_W-1:0];
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         block_count_ff <= BLOCK_COUNT_RESET;
         value_sum_ff   <= '0;
         square_sum_ff  <= '0;
         items_seen_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         block_count_ff <= block_count_in;
         value_sum_ff   <= value_sum_in;
         square_sum_ff  <= square_sum_in;
         items_seen_ff  <= items_seen_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      n_ff         <= n_in;
      last_ff      <= last_in;
      mean_neg_ff  <= mean_neg_in;
      mean_mag_ff  <= mean_mag_in;
      msq2_ff      <= msq2_in;
      var_ff       <= var_in;
      q_ff         <= q_in;
      se_ff        <= se_in;
      rsp_index_ff <= rsp_index_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_se_ff    <= rsp_se_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_item_index     = rsp_index_ff;
   assign rsp_running_mean   = rsp_mean_ff;
   assign rsp_standard_error = rsp_se_ff;
   assign rsp_run_last       = rsp_last_ff;

endmodule

// ===== src/rmse_unit.sv =====
// Shared shift-compare-subtract unit: restoring division or digit-by-digit square root.
module rmse_unit import rmse_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  rmse_cmd_type cmd,
   output rmse_res_type res
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              mode_ff, mode_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [OPND_W-1:0] opnd_ff, opnd_in;
   logic [DIVR_W-1:0] divisor_ff, divisor_in;

   logic [REM_W-1:0]  shifted;
   logic [REM_W-1:0]  trial;
   logic [REM_W:0]    diff;
   logic              fits;

   always_comb begin
      if (mode_ff == MODE_SQRT) begin
         shifted = {rem_ff[REM_W-3:0], opnd_ff[OPND_W-1 -: 2]};
         trial   = {1'b0, quo_ff[SE_W-1:0], 2'b01};
      end else begin
         shifted = {rem_ff[REM_W-2:0], opnd_ff[OPND_W-1]};
         trial   = REM_W'(divisor_ff);
      end
      diff = {1'b0, shifted} - {1'b0, trial};
      fits = !diff[REM_W];
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      mode_in    = mode_ff;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      opnd_in    = opnd_ff;
      divisor_in = divisor_ff;
      if (cmd.start) begin
         busy_in    = 1'b1;
         mode_in    = cmd.mode;
         rem_in     = '0;
         quo_in     = '0;
         divisor_in = cmd.divisor;
         if (cmd.mode == MODE_SQRT) begin
            count_in = ROOT_STEPS;
            opnd_in  = cmd.operand;
         end else begin
            count_in = DIV_STEPS;
            // left-align the dividend so its top bit shifts out first
            opnd_in  = {cmd.operand[QUO_W-1:0], {(OPND_W-QUO_W){1'b0}}};
         end
      end else if (busy_ff) begin
         rem_in   = fits ? diff[REM_W-1:0] : shifted;
         quo_in   = {quo_ff[QUO_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (mode_ff == MODE_SQRT) begin
            opnd_in = {opnd_ff[OPND_W-3:0], 2'b00};
         end else begin
            opnd_in = {opnd_ff[OPND_W-2:0], 1'b0};
         end
         if (count_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff    <= mode_in;
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      opnd_ff    <= opnd_in;
      divisor_ff <= divisor_in;
   end

   assign res.done     = done_ff;
   assign res.quotient = quo_ff;

endmodule

// ===== src/rmse_checker.sv =====
// Port-level checker for the running mean block, bound to the top level.
`include "running_mean_standard_error_top_defines.svh"

module rmse_checker import rmse_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic        [IDX_W-1:0]  rsp_item_index,
   input logic signed [AVG_W-1:0]  rsp_running_mean,
   input logic        [SE_W-1:0]   rsp_standard_error
);

   // first item of a run has no spread
   `RMSE_ASSERT_NOW(first_item_zero_error, clock, reset, rsp_valid && (rsp_item_index == '0), rsp_standard_error == '0, "standard error not zero on first item of run")

   // the block stalls its input right after an input transfer
   `RMSE_ASSERT_NEXT(busy_after_take, clock, reset, req_valid && !req_stall, req_stall, "input taken again while item in work")

   `RMSE_ASSERT_NEXT(result_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_running_mean) && $stable(rsp_standard_error) && $stable(rsp_item_index), "stalled result changed")

   `RMSE_ASSERT_NEXT(idle_after_reset, clock, 1'b0, reset, !rsp_valid && !req_stall, "block not idle after reset")

endmodule

bind running_mean_standard_error_top rmse_checker u_rmse_checker (.*);
